// ===== rtl/core/kcu_pkg.sv =====
`default_nettype none
package kcu_pkg;

  localparam int StateDim = 7;
  localparam int MeasDim  = 9;
  localparam int WordBits = 32;
  localparam int FracBits = 24;

  typedef enum logic [1:0] {
    FUNC_GAIN = 2'd0,
    FUNC_JAC  = 2'd1,
    FUNC_COV  = 2'd2,
    FUNC_CALC = 2'd3
  } func_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [31:0] value;
  } req_t;

endpackage
`default_nettype wire

// ===== rtl/core/kalman_covariance_update_top.sv =====
`default_nettype none
// Load requests: accepted one per cycle while busy is low; each is queued and
// written to its store when the back end pops it. Compute runs on one shared
// multiply-accumulate unit (read, multiply, accumulate per term, one write-back
// per element); then 49 results strobe back to back, last marked. The receiver
// cannot stall them. busy is high while a compute request waits or the queue is
// full. Reset clears control only; stores are undefined.
module kalman_covariance_update_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  func_i,
  input  wire logic [3:0]  row_i,
  input  wire logic [3:0]  col_i,
  input  wire logic [31:0] elem_value_i,
  output logic             strobe,
  output logic [2:0]       out_row_o,
  output logic [2:0]       out_col_o,
  output logic [31:0]      out_value_o,
  output logic             last_o
);
  logic          q_valid, q_pop;
  kcu_pkg::req_t q_req;

  kcu_front u_front (
    .clk_i, .rst_ni, .start_i(start), .func_i, .row_i, .col_i, .elem_value_i,
    .busy_o(busy), .q_valid_o(q_valid), .q_req_o(q_req), .q_pop_i(q_pop));

  kcu_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_req_i(q_req), .q_pop_o(q_pop),
    .valid_o(strobe), .out_row_o, .out_col_o, .out_value_o, .last_o);
endmodule
`default_nettype wire

// ===== rtl/core/kcu_front.sv =====
`default_nettype none
// Accepts requests, drops loads that fall outside their matrix, and queues
// the rest for the back end.
module kcu_front #(
  parameter int QDepth   = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [1:0]     func_i,
  input  wire logic [3:0]     row_i,
  input  wire logic [3:0]     col_i,
  input  wire logic [31:0]    elem_value_i,
  output logic                busy_o,
  output logic                q_valid_o,
  output kcu_pkg::req_t       q_req_o,
  input  wire logic           q_pop_i
);
  localparam int StateDim = kcu_pkg::StateDim;
  localparam int MeasDim  = kcu_pkg::MeasDim;
  localparam int PtrW = $clog2(QDepth);

  kcu_pkg::req_t         mem_q [QDepth];
  logic [PtrW-1:0]       wptr_q, rptr_q;
  logic [PtrW:0]         cnt_q;
  logic                  calc_pend_q;
  logic                  acc, keep, push, pop;
  logic [1:0]            f;

  assign f = func_i;
  always_comb begin
    case (kcu_pkg::func_e'(f))
      kcu_pkg::FUNC_GAIN: keep = 32'(row_i) < StateDim && 32'(col_i) < MeasDim;
      kcu_pkg::FUNC_JAC:  keep = 32'(row_i) < MeasDim && 32'(col_i) < StateDim;
      kcu_pkg::FUNC_COV:  keep = 32'(row_i) < StateDim && 32'(col_i) < StateDim;
      default:            keep = 1'b1;
    endcase
  end

  // A compute request blocks new requests until the back end has taken it,
  // so at most one compute request waits in the queue.
  assign busy_o    = (cnt_q == (PtrW+1)'(QDepth)) || calc_pend_q;
  assign acc       = start_i && !busy_o;
  assign push      = acc && keep;
  assign pop       = q_pop_i && q_valid_o;
  assign q_valid_o = cnt_q != '0;
  assign q_req_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= '{func: func_i, row: row_i, col: col_i, value: elem_value_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
      calc_pend_q <= 1'b0;
    end else begin
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop)  rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
      if (push && kcu_pkg::func_e'(func_i) == kcu_pkg::FUNC_CALC) calc_pend_q <= 1'b1;
      else if (pop && kcu_pkg::func_e'(q_req_o.func) == kcu_pkg::FUNC_CALC)
        calc_pend_q <= 1'b0;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(QDepth)) else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> !pop) else $error("pop of empty queue");
  a_busy_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == (PtrW+1)'(QDepth) |-> busy_o) else $error("full queue not busy");
endmodule
`default_nettype wire

// ===== rtl/core/kcu_back.sv =====
`default_nettype none
// Executes queued requests. Compute runs two passes through one shared
// multiply-accumulate unit: pass A forms I-KH, pass B forms (I-KH)*P into a
// scratch store, then a copy pass writes P back while emitting results.
// Each term steps through memory read, registered product and accumulate;
// each element then adds a write-back step.
module kcu_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  kcu_pkg::req_t       q_req_i,
  output logic                q_pop_o,
  output logic                valid_o,
  output logic [2:0]          out_row_o,
  output logic [2:0]          out_col_o,
  output logic [31:0]         out_value_o,
  output logic                last_o
);
  localparam int StateDim = kcu_pkg::StateDim;
  localparam int MeasDim  = kcu_pkg::MeasDim;
  localparam int WordBits = kcu_pkg::WordBits;
  localparam int FracBits = kcu_pkg::FracBits;
  localparam int NK = StateDim * MeasDim;
  localparam int NP = StateDim * StateDim;
  localparam int DW = (MeasDim > StateDim) ? MeasDim : StateDim;
  localparam int IW = $clog2(DW + 1);
  localparam int AW = $clog2(NK + 1);
  localparam int PW = $clog2(NP + 1);
  localparam logic signed [WordBits-1:0] WMax = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic signed [WordBits-1:0] WMin = {1'b1, {(WordBits-1){1'b0}}};
  localparam logic signed [WordBits:0] One = (WordBits+1)'(1) << FracBits;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_RD = 6'b000010, S_MUL = 6'b000100,
    S_ACC  = 6'b001000, S_WB = 6'b010000, S_EMIT = 6'b100000
  } state_e;

  logic [WordBits-1:0] k_mem [NK];
  logic [WordBits-1:0] h_mem [NK];
  logic [WordBits-1:0] p_mem [NP];
  logic [WordBits-1:0] m_mem [NP];
  logic [WordBits-1:0] n_mem [NP];

  state_e             st_q, st_d;
  logic               pass_q;
  logic [IW-1:0]      i_q, j_q, k_q;
  logic [WordBits-1:0] a_q, b_q, cp_q;
  logic signed [2*WordBits-1:0] prod_q;
  logic signed [WordBits-1:0] acc_q;
  logic [PW-1:0]      e_q;
  logic [PW-1:0]      cpa_q;
  logic               cpw_q;

  function automatic logic signed [WordBits-1:0] sat(input logic signed [2*WordBits:0] v);
    if (v > (2*WordBits+1)'(WMax)) sat = WMax;
    else if (v < (2*WordBits+1)'(WMin)) sat = WMin;
    else sat = WordBits'(v);
  endfunction

  logic [AW-1:0] ld_ka, ld_ha;
  logic [PW-1:0] ld_pa;
  logic          ld;
  // The queue waits while a compute runs and while the last updated element is still being copied into P.
  assign q_pop_o = q_valid_i && st_q == S_IDLE && !cpw_q;
  assign ld    = q_pop_o && kcu_pkg::func_e'(q_req_i.func) != kcu_pkg::FUNC_CALC;
  assign ld_ka = AW'(32'(q_req_i.row) * MeasDim + 32'(q_req_i.col));
  assign ld_ha = AW'(32'(q_req_i.row) * StateDim + 32'(q_req_i.col));
  assign ld_pa = PW'(32'(q_req_i.row) * StateDim + 32'(q_req_i.col));

  logic [IW-1:0] kmax;
  logic          klast, jlast, ilast;
  assign kmax  = pass_q ? IW'(StateDim - 1) : IW'(MeasDim - 1);
  assign klast = k_q == kmax;
  assign jlast = j_q == IW'(StateDim - 1);
  assign ilast = i_q == IW'(StateDim - 1);

  logic [AW-1:0] ra_addr, rb_addr;
  logic [PW-1:0] dst;
  assign ra_addr = AW'(32'(i_q) * (pass_q ? StateDim : MeasDim) + 32'(k_q));
  assign rb_addr = AW'(32'(k_q) * StateDim + 32'(j_q));
  assign dst     = PW'(32'(i_q) * StateDim + 32'(j_q));

  always_ff @(posedge clk_i) begin
    if (ld) begin
      case (kcu_pkg::func_e'(q_req_i.func))
        kcu_pkg::FUNC_GAIN: k_mem[ld_ka] <= q_req_i.value;
        kcu_pkg::FUNC_JAC:  h_mem[ld_ha] <= q_req_i.value;
        default:            p_mem[ld_pa] <= q_req_i.value;
      endcase
    end
    if (st_q == S_RD) begin
      a_q <= pass_q ? m_mem[PW'(ra_addr)] : k_mem[ra_addr];
      b_q <= pass_q ? p_mem[PW'(rb_addr)] : h_mem[rb_addr];
    end
    if (st_q == S_MUL) prod_q <= $signed(a_q) * $signed(b_q);
    if (st_q == S_WB) begin
      if (pass_q) n_mem[dst] <= acc_q;
      else m_mem[dst] <= sat(((i_q == j_q) ? (2*WordBits+1)'(One) : '0)
                             - (2*WordBits+1)'(acc_q));
    end
    // The registered read of the scratch store is written back in the following cycle.
    if (cpw_q) begin
      p_mem[cpa_q] <= cp_q;
    end
    cp_q  <= n_mem[e_q];
    cpa_q <= e_q;
  end

  logic signed [WordBits-1:0] term;
  assign term = sat((2*WordBits+1)'(prod_q >>> FracBits));

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (q_pop_o && kcu_pkg::func_e'(q_req_i.func) == kcu_pkg::FUNC_CALC)
                st_d = S_RD;
      S_RD:   st_d = S_MUL;
      S_MUL:  st_d = S_ACC;
      S_ACC:  st_d = klast ? S_WB : S_RD;
      S_WB:   st_d = (jlast && ilast && pass_q) ? S_EMIT : S_RD;
      S_EMIT: st_d = (e_q == PW'(NP - 1)) ? S_IDLE : S_EMIT;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; pass_q <= 1'b0; cpw_q <= 1'b0;
      i_q <= '0; j_q <= '0; k_q <= '0; acc_q <= '0; e_q <= '0;
      valid_o <= 1'b0; last_o <= 1'b0; out_row_o <= '0; out_col_o <= '0;
    end else begin
      st_q <= st_d;
      valid_o <= 1'b0;
      last_o  <= 1'b0;
      cpw_q   <= st_q == S_EMIT;
      case (st_q)
        S_IDLE: begin
          pass_q <= 1'b0; i_q <= '0; j_q <= '0; k_q <= '0; acc_q <= '0; e_q <= '0;
        end
        S_ACC: begin
          acc_q <= sat((2*WordBits+1)'(acc_q) + (2*WordBits+1)'(term));
          if (!klast) k_q <= k_q + 1'b1;
        end
        S_WB: begin
          acc_q <= '0; k_q <= '0;
          if (!jlast) j_q <= j_q + 1'b1;
          else begin
            j_q <= '0;
            if (!ilast) i_q <= i_q + 1'b1;
            else begin i_q <= '0; pass_q <= 1'b1; end
          end
        end
        S_EMIT: begin
          valid_o   <= 1'b1;
          last_o    <= e_q == PW'(NP - 1);
          out_row_o <= 3'(i_q);
          out_col_o <= 3'(j_q);
          e_q <= e_q + 1'b1;
          if (!jlast) j_q <= j_q + 1'b1;
          else begin j_q <= '0; i_q <= i_q + 1'b1; end
        end
        default: ;
      endcase
    end
  end

  assign out_value_o = 32'(cp_q);

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> valid_o) else $error("last without valid");
  a_emit_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(st_q == S_EMIT) |-> $past(st_q == S_WB)) else $error("bad emit entry");
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != S_IDLE |-> !q_pop_o) else $error("pop while computing");
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NS = 7;
  localparam int NM = 9;
  localparam int FRAC = 24;
  localparam int STALL_LIMIT = 20000;
  localparam logic signed [31:0] WMAX = 32'sh7fffffff;
  localparam logic signed [31:0] WMIN = 32'sh80000000;

  typedef struct {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic        last;
  } cov_elem_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func_i = '0;
  logic [3:0]  row_i = '0;
  logic [3:0]  col_i = '0;
  logic [31:0] elem_value_i = '0;
  logic        strobe;
  logic [2:0]  out_row_o;
  logic [2:0]  out_col_o;
  logic [31:0] out_value_o;
  logic        last_o;

  logic signed [31:0] gain_mat [NS*NM];
  logic signed [31:0] jac_mat [NM*NS];
  logic signed [31:0] cov_mat [NS*NS];
  cov_elem_t   cov_expect_q [$];
  int          mismatches = 0;
  int          stall_cycles = 0;
  bit          idle_en = 1'b1;

  kalman_covariance_update_top DUT (
    .clk_i, .rst_ni, .start, .busy, .func_i, .row_i, .col_i, .elem_value_i,
    .strobe, .out_row_o, .out_col_o, .out_value_o, .last_o
  );

  always #6 clk_i = ~clk_i;

  function automatic logic signed [31:0] sat_word(longint v);
    if (v > longint'(WMAX)) return WMAX;
    if (v < longint'(WMIN)) return WMIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_mul(logic signed [31:0] a,
                                                logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat_word(p >>> FRAC);
  endfunction

  // Applies one accepted request to the predicted stores and queues results.
  task automatic predict_request(kcu_pkg::func_e f, logic [3:0] r, logic [3:0] c,
                                 logic [31:0] v);
    logic signed [31:0] imkh [NS*NS];
    logic signed [31:0] nxt [NS*NS];
    logic signed [31:0] acc;
    longint base;
    cov_elem_t e;
    case (f)
      kcu_pkg::FUNC_GAIN: if (r < NS && c < NM) gain_mat[r*NM + c] = v;
      kcu_pkg::FUNC_JAC:  if (r < NM && c < NS) jac_mat[r*NS + c] = v;
      kcu_pkg::FUNC_COV:  if (r < NS && c < NS) cov_mat[r*NS + c] = v;
      default: begin
        for (int i = 0; i < NS; i++)
          for (int j = 0; j < NS; j++) begin
            acc = 0;
            for (int k = 0; k < NM; k++)
              acc = sat_word(longint'(acc) +
                             longint'(fx_mul(gain_mat[i*NM + k], jac_mat[k*NS + j])));
            base = (i == j) ? (longint'(1) << FRAC) : 0;
            imkh[i*NS + j] = sat_word(base - longint'(acc));
          end
        for (int i = 0; i < NS; i++)
          for (int j = 0; j < NS; j++) begin
            acc = 0;
            for (int k = 0; k < NS; k++)
              acc = sat_word(longint'(acc) +
                             longint'(fx_mul(imkh[i*NS + k], cov_mat[k*NS + j])));
            nxt[i*NS + j] = acc;
          end
        for (int n = 0; n < NS*NS; n++) begin
          cov_mat[n] = nxt[n];
          e.row = 3'(n / NS);
          e.col = 3'(n % NS);
          e.value = nxt[n];
          e.last = (n == NS*NS - 1);
          cov_expect_q.push_back(e);
        end
      end
    endcase
  endtask

  task automatic send_request(kcu_pkg::func_e f, logic [3:0] r, logic [3:0] c,
                              logic [31:0] v);
    if (idle_en && $urandom_range(0, 99) < 18) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start = 1'b1;
    func_i = f;
    row_i = r;
    col_i = c;
    elem_value_i = v;
    do @(posedge clk_i); while (busy);
    predict_request(f, r, c, v);
  endtask

  // Mostly values near unity so repeated updates stay out of saturation.
  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? WMAX : WMIN;
      1, 2: return $urandom;
      default: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
    endcase
  endfunction

  function automatic logic [31:0] small_elem();
    return 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
  endfunction

  task automatic load_all_stores();
    for (int r = 0; r < NS; r++)
      for (int c = 0; c < NM; c++)
        send_request(kcu_pkg::FUNC_GAIN, 4'(r), 4'(c), small_elem());
    // The Jacobian goes in back to back with no idle cycles.
    idle_en = 1'b0;
    for (int r = 0; r < NM; r++)
      for (int c = 0; c < NS; c++)
        send_request(kcu_pkg::FUNC_JAC, 4'(r), 4'(c), small_elem());
    idle_en = 1'b1;
    for (int r = 0; r < NS; r++)
      for (int c = 0; c < NS; c++)
        send_request(kcu_pkg::FUNC_COV, 4'(r), 4'(c), rand_elem());
  endtask

  task automatic test_extreme_values();
    send_request(kcu_pkg::FUNC_CALC, 4'hf, 4'hf, 32'hffff_ffff);
    send_request(kcu_pkg::FUNC_GAIN, 4'd0, 4'd0, WMAX);
    send_request(kcu_pkg::FUNC_GAIN, 4'd6, 4'd8, WMIN);
    send_request(kcu_pkg::FUNC_JAC, 4'd0, 4'd0, WMAX);
    send_request(kcu_pkg::FUNC_JAC, 4'd8, 4'd6, WMIN);
    send_request(kcu_pkg::FUNC_COV, 4'd0, 4'd0, WMIN);
    send_request(kcu_pkg::FUNC_COV, 4'd6, 4'd6, WMAX);
    send_request(kcu_pkg::FUNC_COV, 4'd3, 4'd4, 32'h0);
    send_request(kcu_pkg::FUNC_CALC, 4'h0, 4'h0, 32'h0);
  endtask

  // Loads beyond each matrix's shape must leave every store untouched.
  task automatic test_out_of_shape();
    send_request(kcu_pkg::FUNC_GAIN, 4'd7, 4'd0, 32'h5a5a_5a5a);
    send_request(kcu_pkg::FUNC_GAIN, 4'd0, 4'd9, 32'h5a5a_5a5a);
    send_request(kcu_pkg::FUNC_JAC, 4'd9, 4'd0, 32'ha5a5_a5a5);
    send_request(kcu_pkg::FUNC_JAC, 4'd0, 4'd7, 32'ha5a5_a5a5);
    send_request(kcu_pkg::FUNC_COV, 4'd7, 4'd3, 32'h7fff_0000);
    send_request(kcu_pkg::FUNC_COV, 4'd15, 4'd15, 32'h8000_ffff);
    send_request(kcu_pkg::FUNC_CALC, 4'd9, 4'd12, 32'h1234_5678);
  endtask

  task automatic test_random_mix();
    kcu_pkg::func_e f;
    for (int n = 0; n < 8; n++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_request(kcu_pkg::FUNC_CALC, 4'($urandom), 4'($urandom), $urandom);
      end else begin
        f = kcu_pkg::func_e'($urandom_range(0, 2));
        if ($urandom_range(0, 99) < 85)
          send_request(f, 4'($urandom_range(0, NS - 1)), 4'($urandom_range(0, NS - 1)),
                       rand_elem());
        else
          send_request(f, 4'($urandom), 4'($urandom), rand_elem());
      end
    end
    send_request(kcu_pkg::FUNC_CALC, 4'($urandom), 4'($urandom), $urandom);
  endtask

  always @(posedge clk_i) begin
    cov_elem_t e;
    if (strobe) begin
      if (cov_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: row %0d col %0d value %h", out_row_o, out_col_o,
                   out_value_o);
      end else begin
        e = cov_expect_q.pop_front();
        if (out_row_o !== e.row || out_col_o !== e.col || out_value_o !== e.value ||
            last_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %0d,%0d %h last %b, got %0d,%0d %h last %b",
                     e.row, e.col, e.value, e.last, out_row_o, out_col_o, out_value_o,
                     last_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || strobe || !rst_ni) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    load_all_stores();
    test_extreme_values();
    test_out_of_shape();
    test_random_mix();
    @(negedge clk_i);
    start = 1'b0;
    while (cov_expect_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && cov_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
